// ----- hdl/delta_golomb_audio_encoder_top_defines.svh -----
// Assertion macros shared by the delta Golomb audio encoder RTL.
`ifndef DELTA_GOLOMB_AUDIO_ENCODER_TOP_DEFINES_SVH
`define DELTA_GOLOMB_AUDIO_ENCODER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Invariant checked on every clock edge out of reset.
`define DGAE_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("dgae invariant violated");

// Same-cycle implication.
`define DGAE_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dgae implication violated");

// Next-cycle implication.
`define DGAE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dgae sequence violated");

`else

`define DGAE_ASSERT_ALWAYS(label, cond)
`define DGAE_ASSERT_IMPL(label, ante, cons)
`define DGAE_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ----- hdl/dgae_pkg.sv -----
// Constants, types and helper functions of the delta Golomb audio encoder.
package dgae_pkg;

    localparam int SAMPLE_BITS     = 16;
    localparam int SAMPLE_FIELD_W  = 16;
    // Width of a coded value: the sample field masked to SAMPLE_BITS
    localparam int VAL_W           = (SAMPLE_BITS < SAMPLE_FIELD_W) ? SAMPLE_BITS
                                                                    : SAMPLE_FIELD_W;
    localparam int DIVISOR_W       = 16;
    localparam int MIN_DIVISOR     = 32;
    localparam int RESET_DIVISOR   = 128;
    localparam int RBITS_W         = 5;
    localparam int TAIL_W          = DIVISOR_W + 2;
    localparam int CHUNK_BITS      = 64;
    localparam int MAX_CHUNKS      = 33;
    localparam int MAX_BITS        = MAX_CHUNKS * CHUNK_BITS;
    localparam int COUNT_W         = 7;
    localparam int LEN_W           = ((VAL_W > 12) ? VAL_W : 12) + 1;
    localparam int DIV_CNT_W       = $clog2(VAL_W + 1);

    localparam int APB_ADDR_W      = 3;
    localparam int APB_DATA_W      = 32;
    localparam int REG_IDX_W       = APB_ADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_GOLOMB_DIVISOR = '0;

    localparam int IN_TDATA_W      = SAMPLE_FIELD_W;
    localparam int OUT_TDATA_W     = ((CHUNK_BITS + COUNT_W + 7) / 8) * 8;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_DIV   = 4'b0010,
        ST_SETUP = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    typedef struct packed {
        logic load;
        logic div_step;
        logic setup;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free;
        logic last_chunk;
    } dp_status_t;

    // Bit length of a 16-bit value
    function automatic logic [RBITS_W-1:0] bit_length(input logic [DIVISOR_W-1:0] x);
        logic [RBITS_W-1:0] n;
        n = '0;
        for (int i = 0; i < DIVISOR_W; i++)
        begin
            if (x[i])
            begin
                n = RBITS_W'(i + 1);
            end
        end
        return n;
    endfunction

endpackage

// ----- hdl/dgae_ctrl.sv -----
// Sequencer of the delta Golomb audio encoder: capture, divide, setup, emit.
`include "delta_golomb_audio_encoder_top_defines.svh"

module dgae_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  dgae_pkg::dp_status_t   status,
    output dgae_pkg::ctrl_cmd_t    cmd
);

    dgae_pkg::state_t                    state_reg, state_next;
    logic [dgae_pkg::DIV_CNT_W-1:0]      cnt_reg, cnt_next;

    assign s_tready = (state_reg == dgae_pkg::ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            dgae_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = dgae_pkg::DIV_CNT_W'(dgae_pkg::VAL_W);
                    state_next = dgae_pkg::ST_DIV;
                end
            end
            dgae_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg - dgae_pkg::DIV_CNT_W'(1);
                if (cnt_reg == dgae_pkg::DIV_CNT_W'(1))
                begin
                    state_next = dgae_pkg::ST_SETUP;
                end
            end
            dgae_pkg::ST_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = dgae_pkg::ST_EMIT;
            end
            dgae_pkg::ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.last_chunk)
                    begin
                        state_next = dgae_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = dgae_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dgae_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    `DGAE_ASSERT_NEXT(a_accept_starts_div, state_reg == dgae_pkg::ST_IDLE && s_tvalid, state_reg == dgae_pkg::ST_DIV && cnt_reg == dgae_pkg::DIV_CNT_W'(dgae_pkg::VAL_W))
    `DGAE_ASSERT_NEXT(a_last_chunk_ends, cmd.emit && status.last_chunk, state_reg == dgae_pkg::ST_IDLE)

endmodule

// ----- hdl/dgae_dp.sv -----
// Datapath: residual, bit-serial divider, codeword tail and chunk output register.
`include "delta_golomb_audio_encoder_top_defines.svh"

module dgae_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  dgae_pkg::ctrl_cmd_t                 cmd,
    output dgae_pkg::dp_status_t                status,
    input  logic [dgae_pkg::SAMPLE_FIELD_W-1:0] sample,
    input  logic                                channel_start,
    input  logic [dgae_pkg::DIVISOR_W-1:0]      divisor,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [dgae_pkg::CHUNK_BITS-1:0]     code_bits,
    output logic [dgae_pkg::COUNT_W-1:0]        bit_count,
    output logic                                last_chunk
);

    localparam int VW = dgae_pkg::VAL_W;
    localparam int DW = dgae_pkg::DIVISOR_W;
    localparam int TW = dgae_pkg::TAIL_W;
    localparam int LW = dgae_pkg::LEN_W;
    localparam int RW = dgae_pkg::RBITS_W;

    logic [VW-1:0]  prev_reg, prev_next;
    logic [VW-1:0]  quo_reg, quo_next;
    logic [DW-1:0]  part_reg, part_next;
    logic           sign_reg, sign_next;
    logic [TW-1:0]  tail_reg, tail_next;
    logic [LW-1:0]  rem_reg, rem_next;
    logic           out_valid_reg, out_valid_next;
    logic [dgae_pkg::CHUNK_BITS-1:0] out_bits_reg, out_bits_next;
    logic [dgae_pkg::COUNT_W-1:0]    out_count_reg, out_count_next;
    logic           out_last_reg, out_last_next;

    logic [VW-1:0]  cur;
    logic [VW-1:0]  mag;
    logic           neg;
    logic [DW:0]    trial;
    logic           ge;
    logic [RW-1:0]  rbits;
    logic [LW-1:0]  q_ext, max_q, q_sat;
    logic           is_last;
    logic [LW-1:0]  shift_amt;
    logic [TW-1:0]  tail_mask;
    logic [TW-1:0]  chunk;

    assign cur = sample[VW-1:0];

    // Residual magnitude and sign (previous minus current); a channel start passes the sample itself
    always_comb
    begin
        if (channel_start)
        begin
            mag = cur;
            neg = 1'b0;
        end
        else if (prev_reg >= cur)
        begin
            mag = prev_reg - cur;
            neg = 1'b0;
        end
        else
        begin
            mag = cur - prev_reg;
            neg = 1'b1;
        end
    end

    // One restoring-division step per cycle
    assign trial = {part_reg, quo_reg[VW-1]};
    assign ge    = (trial >= {1'b0, divisor});

    assign rbits = dgae_pkg::bit_length(divisor - DW'(1));
    assign q_ext = LW'(quo_reg);
    assign max_q = LW'(dgae_pkg::MAX_BITS - 2) - LW'(rbits);
    assign q_sat = (q_ext > max_q) ? max_q : q_ext;

    // The codeword is q zeros followed by the tail, so its value is the tail
    assign is_last   = (rem_reg <= LW'(dgae_pkg::CHUNK_BITS));
    assign shift_amt = rem_reg - LW'(dgae_pkg::CHUNK_BITS);
    assign tail_mask = (rem_reg >= LW'(TW)) ? {TW{1'b1}}
                     : ((TW'(1) << rem_reg[RW-1:0]) - TW'(1));

    always_comb
    begin
        if (is_last)
        begin
            chunk = tail_reg & tail_mask;
        end
        else if (shift_amt < LW'(TW))
        begin
            chunk = tail_reg >> shift_amt[RW-1:0];
        end
        else
        begin
            chunk = '0;
        end
    end

    assign status.out_free   = !out_valid_reg || out_ready;
    assign status.last_chunk = is_last;

    always_comb
    begin
        prev_next      = prev_reg;
        quo_next       = quo_reg;
        part_next      = part_reg;
        sign_next      = sign_reg;
        tail_next      = tail_reg;
        rem_next       = rem_reg;
        out_valid_next = out_valid_reg;
        out_bits_next  = out_bits_reg;
        out_count_next = out_count_reg;
        out_last_next  = out_last_reg;

        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd.load)
        begin
            prev_next = cur;
            quo_next  = mag;
            part_next = '0;
            sign_next = neg;
        end

        if (cmd.div_step)
        begin
            part_next = ge ? DW'(trial - {1'b0, divisor}) : trial[DW-1:0];
            quo_next  = {quo_reg[VW-2:0], ge};
        end

        if (cmd.setup)
        begin
            rem_next  = q_sat + LW'(rbits) + LW'(2);
            tail_next = (TW'(1) << (rbits + RW'(1))) | TW'({part_reg, sign_reg});
        end

        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            out_bits_next  = dgae_pkg::CHUNK_BITS'(chunk);
            out_count_next = is_last ? dgae_pkg::COUNT_W'(rem_reg)
                                     : dgae_pkg::COUNT_W'(dgae_pkg::CHUNK_BITS);
            out_last_next  = is_last;
            rem_next       = shift_amt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            prev_reg      <= prev_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg       <= quo_next;
        part_reg      <= part_next;
        sign_reg      <= sign_next;
        tail_reg      <= tail_next;
        rem_reg       <= rem_next;
        out_bits_reg  <= out_bits_next;
        out_count_reg <= out_count_next;
        out_last_reg  <= out_last_next;
    end

    assign out_valid  = out_valid_reg;
    assign code_bits  = out_bits_reg;
    assign bit_count  = out_count_reg;
    assign last_chunk = out_last_reg;

    `DGAE_ASSERT_IMPL(a_count_in_range, out_valid_reg, out_count_reg != '0 && out_count_reg <= dgae_pkg::COUNT_W'(dgae_pkg::CHUNK_BITS))
    `DGAE_ASSERT_IMPL(a_inner_chunk_full, out_valid_reg && !out_last_reg, out_count_reg == dgae_pkg::COUNT_W'(dgae_pkg::CHUNK_BITS))

endmodule

// ----- hdl/delta_golomb_audio_encoder_top.sv -----
// Top level of the delta Golomb audio encoder: APB register, sequencer, datapath.
//
// Codes 16-bit offset audio samples with first-order prediction and Golomb
// codes. A sample transfer carries the sample in s_axis_tdata and the
// channel-start flag in s_axis_tuser; a flagged sample is coded as itself,
// any other as the residual previous minus current (magnitude plus sign).
// The codeword is q = v/m zeros, a one, v mod m in bitlen(m-1) bits MSB
// first, then the sign bit; it leaves on the master side as chunks of up to
// 64 bits, first bit at position bit_count-1, tlast on the final chunk.
// Each item passes capture, the one-bit-per-cycle restoring divider and
// setup, then leaves as N chunks (1..33), one chunk per cycle as the output
// register drains, as long as the master side takes each chunk; back-pressure
// on the master side holds the encoder in the emit state.
// A new sample is taken once the last chunk of the previous one sits in the
// output register. The Golomb divisor m lives at APB offset 0 (reset 128,
// writes below 32 stored as 32); write it only while the encoder is idle.
`include "delta_golomb_audio_encoder_top_defines.svh"

module delta_golomb_audio_encoder_top (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // stream input
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [dgae_pkg::IN_TDATA_W-1:0]       s_axis_tdata,  // [15:0] sample
    input  logic                                  s_axis_tuser,  // [0] channel_start
    // stream output
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [dgae_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,  // [63:0] code_bits,
                                                                 // [70:64] bit_count
    output logic                                  m_axis_tlast,  // last_chunk
    // APB configuration
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [dgae_pkg::APB_ADDR_W-1:0]       paddr,
    input  logic [dgae_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [dgae_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                  pready
);

    logic [dgae_pkg::DIVISOR_W-1:0]  divisor_reg, divisor_next;
    logic [dgae_pkg::DIVISOR_W-1:0]  wr_value;
    logic                            reg_hit;
    logic                            wr_en;

    dgae_pkg::ctrl_cmd_t             cmd;
    dgae_pkg::dp_status_t            status;

    logic [dgae_pkg::CHUNK_BITS-1:0] code_bits;
    logic [dgae_pkg::COUNT_W-1:0]    bit_count;

    // APB register file: single register, no wait states
    assign pready   = 1'b1;
    assign reg_hit  = (paddr[dgae_pkg::APB_ADDR_W-1:2] == dgae_pkg::REG_GOLOMB_DIVISOR);
    assign wr_en    = psel && penable && pwrite && reg_hit;
    assign wr_value = pwdata[dgae_pkg::DIVISOR_W-1:0];

    // Clamp the divisor to its minimum on write
    always_comb
    begin
        divisor_next = divisor_reg;
        if (wr_en)
        begin
            if (wr_value < dgae_pkg::DIVISOR_W'(dgae_pkg::MIN_DIVISOR))
            begin
                divisor_next = dgae_pkg::DIVISOR_W'(dgae_pkg::MIN_DIVISOR);
            end
            else
            begin
                divisor_next = wr_value;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            divisor_reg <= dgae_pkg::DIVISOR_W'(dgae_pkg::RESET_DIVISOR);
        end
        else
        begin
            divisor_reg <= divisor_next;
        end
    end

    assign prdata = reg_hit ? dgae_pkg::APB_DATA_W'(divisor_reg) : '0;

    // Sequencer
    dgae_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath with the output register
    dgae_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .sample        (s_axis_tdata),
        .channel_start (s_axis_tuser),
        .divisor       (divisor_reg),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .code_bits     (code_bits),
        .bit_count     (bit_count),
        .last_chunk    (m_axis_tlast)
    );

    // Pack code_bits low, bit_count above, zero pad to whole bytes
    assign m_axis_tdata = dgae_pkg::OUT_TDATA_W'({bit_count, code_bits});

    `DGAE_ASSERT_ALWAYS(a_divisor_min, divisor_reg >= dgae_pkg::DIVISOR_W'(dgae_pkg::MIN_DIVISOR))

endmodule
